// ----- src/tti_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Time table interpolator package
// Shared sizes, operation codes and controller states of the interpolator.
// ----------------------------------------------------------------------------
package tti_pkg;

  // Table geometry.
  localparam int MAX_ROWS = 256;
  localparam int ROW_AW   = $clog2(MAX_ROWS);
  localparam int CNT_W    = ROW_AW + 1;
  localparam int VAL_W    = 32;

  // Bits of the full product |dt|*|dx|, one divider step per bit.
  localparam int DIV_STEPS = 65;
  localparam int STEP_W    = $clog2(DIV_STEPS);

  // Operation codes carried by the mode field.
  typedef enum logic [1:0] {
    MODE_CLEAR  = 2'd0,
    MODE_APPEND = 2'd1,
    MODE_VALUE  = 2'd2,
    MODE_EVENT  = 2'd3
  } mode_e;

  // Controller states, one-hot.
  typedef enum logic [6:0] {
    ST_IDLE = 7'b0000001,
    ST_SCAN = 7'b0000010,
    ST_VFIN = 7'b0000100,
    ST_MUL1 = 7'b0001000,
    ST_MUL2 = 7'b0010000,
    ST_DIV  = 7'b0100000,
    ST_SUM  = 7'b1000000
  } state_e;

endpackage

// ----- src/tti_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic single-port-write, single-port-read RAM
// One write and one read per cycle; the read data is registered.
// ----------------------------------------------------------------------------
module tti_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port and registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- src/time_table_interpolator_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Time table interpolator core
// Table of (time, value) rows with value interpolation and next event search.
// ----------------------------------------------------------------------------
// Usage: a command word is taken at a clock edge with start high and busy low.
// mode selects clear, append, value query or next event query. Every command
// gives exactly one result word, shown for one cycle with done_o high; the
// receiver cannot hold it off, so it must take it in that cycle.
// Rows live in one 64-bit RAM (time, value) with a registered read port.
// Clear, append and queries that need no table walk finish straight from idle.
// A value query walks the rows one per cycle, at most the row count, then
// settles the result in ST_VFIN; an interpolated value goes on to the product
// in ST_MUL1 and ST_MUL2, the bit-serial divider in ST_DIV, the sum in ST_SUM.
// A next event query walks the rows until a hit or the last row.
// One command is in flight at a time; busy is high until its result.
// variable_is_discrete is written through cfg_we_i/cfg_wdata_i; the user
// must write it only while idle, which the block does not enforce. Reset
// empties the table (row count zero) and clears the register; the RAM itself
// is not cleared, as rows past the count are never read.
// ----------------------------------------------------------------------------
module time_table_interpolator_core (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start,
  output logic                       busy,
  input  logic [1:0]                 mode_i,
  input  logic signed [31:0]         time_point_i,
  input  logic signed [31:0]         sample_value_i,
  input  logic                       after_event_i,
  input  logic                       apply_continuous_i,
  input  logic                       apply_discrete_i,
  input  logic                       cfg_we_i,
  input  logic                       cfg_wdata_i,
  output logic                       done_o,
  output logic signed [31:0]         result_value_o,
  output logic                       value_valid_o,
  output logic signed [31:0]         event_time_o,
  output logic                       event_found_o,
  output logic                       table_full_o
);

  import tti_pkg::*;

  localparam logic signed [34:0] SAT_MAX = 35'sd2147483647;
  localparam logic signed [34:0] SAT_MIN = -35'sd2147483648;

  // Control registers.
  state_e                   state_q;
  logic [CNT_W-1:0]         cnt_q;
  logic                     disc_q;
  logic [CNT_W-1:0]         ra_q;
  logic                     pv_q;
  logic [ROW_AW-1:0]        pidx_q;
  logic                     phb_q;
  logic [ROW_AW-1:0]        row_q;
  logic                     nxt_ok_q;
  logic                     is_evt_q;
  logic [STEP_W-1:0]        step_q;
  logic                     done_q;
  logic                     valid_q;
  logic                     found_q;
  logic                     full_q;
  logic signed [VAL_W-1:0]  res_q;
  logic signed [VAL_W-1:0]  evt_q;

  // Datapath registers.
  logic signed [VAL_W-1:0]  t_q;
  logic                     after_q;
  logic signed [VAL_W-1:0]  sel_t_q;
  logic signed [VAL_W-1:0]  sel_x_q;
  logic signed [VAL_W-1:0]  nxt_t_q;
  logic signed [VAL_W-1:0]  nxt_x_q;
  logic [32:0]              dtm_q;
  logic [32:0]              dxm_q;
  logic [32:0]              dtd_q;
  logic                     neg_q;
  logic [48:0]              pp_q;
  logic [64:0]              dvd_q;
  logic [32:0]              rem_q;
  logic [32:0]              quo_q;
  logic                     ovf_q;

  // Row memory.
  logic                     mem_we;
  logic [63:0]              mem_rdata;
  logic signed [VAL_W-1:0]  rd_t;
  logic signed [VAL_W-1:0]  rd_x;

  tti_ram #(
    .WIDTH (64),
    .DEPTH (MAX_ROWS)
  ) u_row_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (cnt_q[ROW_AW-1:0]),
    .wdata_i ({time_point_i, sample_value_i}),
    .raddr_i (ra_q[ROW_AW-1:0]),
    .rdata_o (mem_rdata)
  );

  assign rd_t = mem_rdata[63:32];
  assign rd_x = mem_rdata[31:0];

  // Handshake and command decode.
  logic accept;
  logic served;
  logic has_room;
  assign busy     = (state_q != ST_IDLE);
  assign accept   = start && !busy;
  assign served   = disc_q ? apply_discrete_i : apply_continuous_i;
  assign has_room = (cnt_q < CNT_W'(MAX_ROWS));
  assign mem_we   = accept && (mode_e'(mode_i) == MODE_APPEND) && has_room;

  // Table walk: one read issued per cycle while rows remain.
  logic issue;
  assign issue = (state_q == ST_SCAN) && (ra_q < cnt_q);

  // Row selection for a value query, evaluated on the returning row.
  logic [CNT_W-1:0] lim;
  logic             k_first;
  logic             k_last;
  logic             row_ok;
  logic             t_lt;
  logic             t_le;
  logic             v_acc;
  assign k_first = (pidx_q == '0);
  assign k_last  = ({1'b0, pidx_q} == (cnt_q - CNT_W'(1)));
  assign lim     = disc_q ? (cnt_q - CNT_W'(1)) : (cnt_q - CNT_W'(2));
  assign row_ok  = ({1'b0, row_q} < lim);
  assign t_lt    = (rd_t < t_q);
  assign t_le    = (rd_t <= t_q);
  assign v_acc   = k_first ||
                   (phb_q ? (after_q && row_ok && t_le)
                          : (t_lt || (after_q && row_ok && t_le)));

  // Next event check on the pair (previous row, returning row).
  logic                    e_eq;
  logic                    e_hit;
  logic signed [VAL_W-1:0] e_time;
  assign e_eq   = (sel_t_q == rd_t);
  assign e_hit  = !k_first && (t_q < rd_t) &&
                  (e_eq || (disc_q && (sel_x_q != rd_x)));
  assign e_time = e_eq ? sel_t_q : rd_t;

  // Differences for interpolation.
  logic signed [32:0] dt33;
  logic signed [32:0] dx33;
  logic signed [32:0] dT33;
  assign dt33 = 33'(t_q) - 33'(sel_t_q);
  assign dx33 = 33'(nxt_x_q) - 33'(sel_x_q);
  assign dT33 = 33'(nxt_t_q) - 33'(sel_t_q);

  logic hold_val;
  assign hold_val = disc_q || !nxt_ok_q || (dT33 == '0);

  // Second partial product and full product.
  logic [49:0] ph;
  logic [65:0] prod;
  assign ph   = dtm_q * dxm_q[32:16];
  assign prod = {17'b0, pp_q} + {ph, 16'b0};

  // One restoring divider step.
  logic [33:0] r2;
  logic        ge;
  logic [33:0] r2_sub;
  assign r2     = {rem_q, dvd_q[64]};
  assign ge     = (r2 >= {1'b0, dtd_q});
  assign r2_sub = r2 - {1'b0, dtd_q};

  // Final sum with saturation.
  logic signed [34:0] xs;
  logic signed [34:0] qs;
  logic signed [34:0] sum;
  logic signed [VAL_W-1:0] sat;
  assign xs  = 35'(sel_x_q);
  assign qs  = signed'({2'b0, quo_q});
  assign sum = neg_q ? (xs - qs) : (xs + qs);
  always_comb begin
    if (ovf_q) begin
      sat = neg_q ? VAL_W'(SAT_MIN) : VAL_W'(SAT_MAX);
    end else if (sum > SAT_MAX) begin
      sat = VAL_W'(SAT_MAX);
    end else if (sum < SAT_MIN) begin
      sat = VAL_W'(SAT_MIN);
    end else begin
      sat = sum[VAL_W-1:0];
    end
  end

  // Controller and result word.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      cnt_q    <= '0;
      disc_q   <= 1'b0;
      ra_q     <= '0;
      pv_q     <= 1'b0;
      pidx_q   <= '0;
      phb_q    <= 1'b0;
      row_q    <= '0;
      nxt_ok_q <= 1'b0;
      is_evt_q <= 1'b0;
      step_q   <= '0;
      done_q   <= 1'b0;
      valid_q  <= 1'b0;
      found_q  <= 1'b0;
      full_q   <= 1'b0;
      res_q    <= '0;
      evt_q    <= '0;
    end else begin
      done_q <= 1'b0;
      if (cfg_we_i) begin
        disc_q <= cfg_wdata_i;
      end
      case (state_q)
        ST_IDLE: begin
          if (accept) begin
            valid_q  <= 1'b0;
            found_q  <= 1'b0;
            full_q   <= 1'b0;
            res_q    <= '0;
            evt_q    <= '0;
            ra_q     <= '0;
            pv_q     <= 1'b0;
            phb_q    <= 1'b0;
            row_q    <= '0;
            nxt_ok_q <= 1'b0;
            case (mode_e'(mode_i))
              MODE_CLEAR: begin
                cnt_q  <= '0;
                done_q <= 1'b1;
              end
              MODE_APPEND: begin
                if (has_room) begin
                  cnt_q <= cnt_q + CNT_W'(1);
                end else begin
                  full_q <= 1'b1;
                end
                done_q <= 1'b1;
              end
              MODE_VALUE: begin
                if ((cnt_q != '0) && served) begin
                  is_evt_q <= 1'b0;
                  state_q  <= ST_SCAN;
                end else begin
                  done_q <= 1'b1;
                end
              end
              MODE_EVENT: begin
                if (cnt_q >= CNT_W'(2)) begin
                  is_evt_q <= 1'b1;
                  state_q  <= ST_SCAN;
                end else begin
                  done_q <= 1'b1;
                end
              end
              default: begin
                done_q <= 1'b1;
              end
            endcase
          end
        end
        ST_SCAN: begin
          ra_q   <= ra_q + CNT_W'(issue);
          pv_q   <= issue;
          pidx_q <= ra_q[ROW_AW-1:0];
          if (pv_q) begin
            if (!is_evt_q) begin
              if (v_acc) begin
                row_q    <= pidx_q;
                nxt_ok_q <= 1'b0;
                phb_q    <= phb_q || (!k_first && !t_lt);
                if (k_last) begin
                  state_q <= ST_VFIN;
                end
              end else begin
                nxt_ok_q <= 1'b1;
                state_q  <= ST_VFIN;
              end
            end else if (e_hit) begin
              found_q <= 1'b1;
              evt_q   <= e_time;
              done_q  <= 1'b1;
              state_q <= ST_IDLE;
            end else if (k_last) begin
              done_q  <= 1'b1;
              state_q <= ST_IDLE;
            end
          end
        end
        ST_VFIN: begin
          if (hold_val) begin
            res_q   <= sel_x_q;
            valid_q <= 1'b1;
            done_q  <= 1'b1;
            state_q <= ST_IDLE;
          end else begin
            state_q <= ST_MUL1;
          end
        end
        ST_MUL1: begin
          state_q <= ST_MUL2;
        end
        ST_MUL2: begin
          step_q  <= '0;
          state_q <= ST_DIV;
        end
        ST_DIV: begin
          step_q <= step_q + STEP_W'(1);
          if (step_q == STEP_W'(DIV_STEPS - 1)) begin
            state_q <= ST_SUM;
          end
        end
        ST_SUM: begin
          res_q   <= sat;
          valid_q <= 1'b1;
          done_q  <= 1'b1;
          state_q <= ST_IDLE;
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  // Datapath: captured rows, product and divider.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      t_q     <= time_point_i;
      after_q <= after_event_i;
    end
    if ((state_q == ST_SCAN) && pv_q) begin
      if (is_evt_q || v_acc) begin
        sel_t_q <= rd_t;
        sel_x_q <= rd_x;
      end else begin
        nxt_t_q <= rd_t;
        nxt_x_q <= rd_x;
      end
    end
    if (state_q == ST_VFIN) begin
      dtm_q <= dt33[32] ? 33'(-dt33) : 33'(dt33);
      dxm_q <= dx33[32] ? 33'(-dx33) : 33'(dx33);
      dtd_q <= dT33[32] ? 33'(-dT33) : 33'(dT33);
      neg_q <= dt33[32] ^ dx33[32] ^ dT33[32];
    end
    if (state_q == ST_MUL1) begin
      pp_q <= dtm_q * dxm_q[15:0];
    end
    if (state_q == ST_MUL2) begin
      dvd_q <= prod[64:0];
      rem_q <= '0;
      quo_q <= '0;
      ovf_q <= 1'b0;
    end
    if (state_q == ST_DIV) begin
      rem_q <= ge ? r2_sub[32:0] : r2[32:0];
      quo_q <= {quo_q[31:0], ge};
      ovf_q <= ovf_q | quo_q[32];
      dvd_q <= {dvd_q[63:0], 1'b0};
    end
  end

  // Result ports.
  assign done_o         = done_q;
  assign result_value_o = res_q;
  assign value_valid_o  = valid_q;
  assign event_time_o   = evt_q;
  assign event_found_o  = found_q;
  assign table_full_o   = full_q;

  // Checks on the table count and result word.
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(MAX_ROWS))
    else $error("row count beyond table size");

  a_one_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(value_valid_o && event_found_o))
    else $error("value and event flagged in one word");

  a_full_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && table_full_o) |-> (cnt_q == CNT_W'(MAX_ROWS)))
    else $error("append dropped with room left");

  a_append_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (mode_e'(mode_i) == MODE_APPEND) && has_room)
      |=> (cnt_q == $past(cnt_q) + CNT_W'(1)))
    else $error("append did not advance the row count");

  a_scan_bounds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN) |-> (ra_q <= cnt_q))
    else $error("table walk ran past the last row");

endmodule
